[rtl/lshm_pkg.sv]
// Shared types and constants for the latency statistics histogram monitor.
`timescale 1ns / 1ps

package lshm_pkg;

    localparam int LSHM_NUM_STAGES = 64;
    localparam int NUM_BUCKETS     = 16;
    localparam int BKT_W           = 4;

    localparam logic [2:0] FN_RECORD   = 3'd0;
    localparam logic [2:0] FN_READ     = 3'd1;
    localparam logic [2:0] FN_DROPS    = 3'd2;
    localparam logic [2:0] FN_REPLACED = 3'd3;
    localparam logic [2:0] FN_STALLS   = 3'd4;
    localparam logic [2:0] FN_CLEAR    = 3'd5;

    // Upper bucket bounds in ns; the last bucket is unbounded.
    localparam logic [63:0] BOUND_NS [NUM_BUCKETS] = '{
        64'd100000,    64'd250000,    64'd500000,    64'd1000000,
        64'd2000000,   64'd4000000,   64'd8000000,   64'd16000000,
        64'd25000000,  64'd33000000,  64'd50000000,  64'd66000000,
        64'd100000000, 64'd250000000, 64'd500000000, 64'hFFFF_FFFF_FFFF_FFFF
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UPD,
        ST_REC,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] count;
        logic [63:0] total;
        logic [63:0] max;
        logic [63:0] recent;
        logic [63:0] over;
    } stat_row_t;

    typedef struct packed {
        logic        accepted;
        logic [63:0] sample_count;
        logic [63:0] total_time;
        logic [63:0] max_time;
        logic [63:0] recent_time;
        logic [63:0] over_budget_count;
        logic [63:0] p95_time;
        logic [63:0] drops_total;
        logic [63:0] replaced_total;
        logic [63:0] stalls_total;
    } result_t;

endpackage

[rtl/lshm_ifs.sv]
// Request and response channel interfaces of the latency monitor.
`timescale 1ns / 1ps

interface lshm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [5:0]  stage;
    logic [63:0] begin_ns;
    logic [63:0] end_ns;
    logic [31:0] event_count;

    modport source (output valid, func, stage, begin_ns, end_ns, event_count, input ready);
    modport sink   (input valid, func, stage, begin_ns, end_ns, event_count, output ready);
endinterface

interface lshm_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [63:0] sample_count;
    logic [63:0] total_time;
    logic [63:0] max_time;
    logic [63:0] recent_time;
    logic [63:0] over_budget_count;
    logic [63:0] p95_time;
    logic [63:0] drops_total;
    logic [63:0] replaced_total;
    logic [63:0] stalls_total;

    modport source (output valid, accepted, sample_count, total_time, max_time, recent_time,
                    over_budget_count, p95_time, drops_total, replaced_total, stalls_total,
                    input ready);
    modport sink   (input valid, accepted, sample_count, total_time, max_time, recent_time,
                    over_budget_count, p95_time, drops_total, replaced_total, stalls_total,
                    output ready);
endinterface

[rtl/latency_stats_histogram_monitor.sv]
// Per-stage latency monitor: statistics memory, histogram memory and control sequencer.
// One transaction at a time. When the addressed stage holds samples after the step, an item
// goes through load, update, recent value and p95 target, a walk over the 16 histogram buckets
// through the single read port of the bucket memory, then the output load, which also writes the
// stage row back for a record; when the stage is empty or out of range the walk is skipped. The
// result sits in an output register, so the next request can be taken in the cycle after the result
// is loaded, while it waits; the output load stalls while an earlier result has not been taken.
// Reset and clear-all drop one valid flag per stage instead of a clearing pass; both zero the global counters.
`timescale 1ns / 1ps

module latency_stats_histogram_monitor #(
    parameter int NUM_STAGES = lshm_pkg::LSHM_NUM_STAGES
) (
    input  logic          clk,
    input  logic          rst_n,
    lshm_req_if.sink      req,
    lshm_rsp_if.source    rsp,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata
);

    localparam int SIDX_W   = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int BADDR_W  = SIDX_W + lshm_pkg::BKT_W;
    localparam int BDEPTH   = NUM_STAGES * lshm_pkg::NUM_BUCKETS;

    // control
    lshm_pkg::state_t state_reg, state_next;
    logic             req_ready;
    logic             row_we;
    logic             load_out;
    logic             out_vld_reg;
    logic [31:0]      budget_reg;
    logic [63:0]      drops_reg, repl_reg, stalls_reg;
    logic [NUM_STAGES-1:0] row_vld_reg;
    logic             accept;

    // request latch
    logic [2:0]        func_reg;
    logic [SIDX_W-1:0] idx_reg;
    logic              inr_reg;
    logic [63:0]       start_reg, end_reg;
    logic [7:0]        stage8;
    logic              stage_inr;

    // datapath
    lshm_pkg::stat_row_t row_reg;
    lshm_pkg::stat_row_t st_mem [NUM_STAGES];
    lshm_pkg::stat_row_t st_q;
    logic [63:0]       bkt_mem [BDEPTH];
    logic [63:0]       bkt_q;
    logic [63:0]       x_reg;
    logic              neg_reg;
    logic              do_rec;
    logic              was_vld_reg;
    logic              first_reg;
    logic [63:0]       seven_reg;
    logic [3:0]        bkt_reg;
    logic [3:0]        bkt_sel;
    logic [70:0]       n95_reg;
    logic [4:0]        cnt_reg;
    logic [4:0]        cm1, cm2;
    logic [63:0]       sum_reg;
    logic [70:0]       sum100;
    logic              found_reg;
    logic [63:0]       p95_reg;
    logic [63:0]       bkt_val, bkt_new;
    logic              bkt_hit, bkt_we, walk_data, walk_cmp;
    logic              start_walk;
    lshm_pkg::result_t res_reg;

    assign stage8    = {2'b00, req.stage};
    assign stage_inr = (32'(req.stage) < 32'(NUM_STAGES));
    assign accept    = req.valid && req_ready;
    assign req.ready = req_ready;
    assign do_rec    = (func_reg == lshm_pkg::FN_RECORD) && inr_reg && !neg_reg;

    // walk bookkeeping: read issued at cnt, data in the next cycle, compare in the cycle after that
    assign cm1       = cnt_reg - 5'd1;
    assign cm2       = cnt_reg - 5'd2;
    assign walk_data = (state_reg == lshm_pkg::ST_WALK) && (cnt_reg >= 5'd1) && (cnt_reg <= 5'd16);
    assign walk_cmp  = (state_reg == lshm_pkg::ST_WALK) && (cnt_reg >= 5'd2);
    assign bkt_val   = was_vld_reg ? bkt_q : 64'd0;
    assign bkt_hit   = do_rec && (cm1[3:0] == bkt_reg);
    assign bkt_new   = bkt_val + {63'd0, bkt_hit};
    // a stage recorded for the first time since clear rewrites all its buckets
    assign bkt_we    = walk_data && do_rec && (!was_vld_reg || bkt_hit);
    assign sum100    = ({7'd0, sum_reg} << 6) + ({7'd0, sum_reg} << 5) + ({7'd0, sum_reg} << 2);
    assign start_walk = inr_reg && (row_reg.count != 64'd0);

    always_comb
    begin
        bkt_sel = 4'd15;
        for (int b = lshm_pkg::NUM_BUCKETS - 2; b >= 0; b--)
        begin
            if (x_reg <= lshm_pkg::BOUND_NS[b])
            begin
                bkt_sel = 4'(b);
            end
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lshm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        row_we     = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            lshm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    state_next = lshm_pkg::ST_LOAD;
                end
            end
            lshm_pkg::ST_LOAD: state_next = lshm_pkg::ST_UPD;
            lshm_pkg::ST_UPD:  state_next = lshm_pkg::ST_REC;
            lshm_pkg::ST_REC:
            begin
                state_next = start_walk ? lshm_pkg::ST_WALK : lshm_pkg::ST_DONE;
            end
            lshm_pkg::ST_WALK:
            begin
                if (cnt_reg == 5'd17)
                begin
                    state_next = lshm_pkg::ST_DONE;
                end
            end
            lshm_pkg::ST_DONE:
            begin
                load_out = !out_vld_reg || rsp.ready;
                // row holds the final recent value by now
                row_we   = do_rec && load_out;
                if (load_out)
                begin
                    state_next = lshm_pkg::ST_IDLE;
                end
            end
            default: state_next = lshm_pkg::ST_IDLE;
        endcase
    end

    // control registers, global counters, stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            budget_reg  <= 32'd0;
            drops_reg   <= 64'd0;
            repl_reg    <= 64'd0;
            stalls_reg  <= 64'd0;
            row_vld_reg <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                budget_reg <= cfg_wdata;
            end
            if (accept)
            begin
                case (req.func)
                    lshm_pkg::FN_DROPS:    drops_reg  <= drops_reg + {32'd0, req.event_count};
                    lshm_pkg::FN_REPLACED: repl_reg   <= repl_reg + {32'd0, req.event_count};
                    lshm_pkg::FN_STALLS:   stalls_reg <= stalls_reg + {32'd0, req.event_count};
                    lshm_pkg::FN_CLEAR:
                    begin
                        drops_reg   <= 64'd0;
                        repl_reg    <= 64'd0;
                        stalls_reg  <= 64'd0;
                        row_vld_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (row_we)
            begin
                row_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // statistics memory: one row per stage
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            st_mem[idx_reg] <= row_reg;
        end
        st_q <= st_mem[stage8[SIDX_W-1:0]];
    end

    // histogram memory: 16 buckets per stage
    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[{idx_reg, cm1[3:0]}] <= bkt_new;
        end
        bkt_q <= bkt_mem[{idx_reg, cnt_reg[3:0]}];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lshm_pkg::ST_IDLE:
            begin
                func_reg  <= req.func;
                idx_reg   <= stage8[SIDX_W-1:0];
                inr_reg   <= stage_inr;
                start_reg <= req.begin_ns;
                end_reg   <= req.end_ns;
            end
            lshm_pkg::ST_LOAD:
            begin
                was_vld_reg <= inr_reg && row_vld_reg[idx_reg];
                row_reg     <= (inr_reg && row_vld_reg[idx_reg]) ? st_q : '0;
                x_reg       <= end_reg - start_reg;
                neg_reg     <= end_reg < start_reg;
            end
            lshm_pkg::ST_UPD:
            begin
                first_reg <= (row_reg.count == 64'd0);
                seven_reg <= (row_reg.recent << 3) - row_reg.recent;
                bkt_reg   <= bkt_sel;
                if (do_rec)
                begin
                    row_reg.count <= row_reg.count + 64'd1;
                    row_reg.total <= row_reg.total + x_reg;
                    if (x_reg > row_reg.max)
                    begin
                        row_reg.max <= x_reg;
                    end
                    if ((budget_reg != 32'd0) && (x_reg > {32'd0, budget_reg}))
                    begin
                        row_reg.over <= row_reg.over + 64'd1;
                    end
                end
            end
            lshm_pkg::ST_REC:
            begin
                if (do_rec)
                begin
                    row_reg.recent <= first_reg ? x_reg : ((seven_reg + x_reg + 64'd4) >> 3);
                end
                // 95*n = 128n - 32n - n
                n95_reg   <= ({7'd0, row_reg.count} << 7) - ({7'd0, row_reg.count} << 5)
                             - {7'd0, row_reg.count};
                cnt_reg   <= 5'd0;
                sum_reg   <= 64'd0;
                found_reg <= 1'b0;
                p95_reg   <= start_walk ? lshm_pkg::BOUND_NS[lshm_pkg::NUM_BUCKETS-1] : 64'd0;
            end
            lshm_pkg::ST_WALK:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (walk_data)
                begin
                    sum_reg <= sum_reg + bkt_new;
                end
                // sum >= ceil(95n/100)  <=>  100*sum >= 95n
                if (walk_cmp && !found_reg && (sum100 >= n95_reg))
                begin
                    found_reg <= 1'b1;
                    p95_reg   <= lshm_pkg::BOUND_NS[cm2[3:0]];
                end
            end
            default: ;
        endcase
        if (load_out)
        begin
            res_reg.accepted          <= (func_reg != lshm_pkg::FN_RECORD) || do_rec;
            res_reg.sample_count      <= row_reg.count;
            res_reg.total_time        <= row_reg.total;
            res_reg.max_time          <= row_reg.max;
            res_reg.recent_time       <= row_reg.recent;
            res_reg.over_budget_count <= row_reg.over;
            res_reg.p95_time          <= p95_reg;
            res_reg.drops_total       <= drops_reg;
            res_reg.replaced_total    <= repl_reg;
            res_reg.stalls_total      <= stalls_reg;
        end
    end

    assign rsp.valid             = out_vld_reg;
    assign rsp.accepted          = res_reg.accepted;
    assign rsp.sample_count      = res_reg.sample_count;
    assign rsp.total_time        = res_reg.total_time;
    assign rsp.max_time          = res_reg.max_time;
    assign rsp.recent_time       = res_reg.recent_time;
    assign rsp.over_budget_count = res_reg.over_budget_count;
    assign rsp.p95_time          = res_reg.p95_time;
    assign rsp.drops_total       = res_reg.drops_total;
    assign rsp.replaced_total    = res_reg.replaced_total;
    assign rsp.stalls_total      = res_reg.stalls_total;

endmodule

[bench/latency_stats_histogram_monitor_tb.sv]
// Self-checking bench for the latency statistics histogram monitor.
`timescale 1ns / 1ps

module latency_stats_histogram_monitor_tb;

    localparam int CLK_HALF    = 4;
    localparam int SETTLE      = 30;    // covers a full item plus margin
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 6;

    // func codes with no name in the package; the block treats them as reads
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [63:0] BUCKET_TOP [lshm_pkg::NUM_BUCKETS] = '{
        64'd100000,    64'd250000,    64'd500000,    64'd1000000,
        64'd2000000,   64'd4000000,   64'd8000000,   64'd16000000,
        64'd25000000,  64'd33000000,  64'd50000000,  64'd66000000,
        64'd100000000, 64'd250000000, 64'd500000000, MAX64
    };

    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  stage;
        logic [63:0] begin_ns;
        logic [63:0] end_ns;
        logic [31:0] event_count;
    } stat_req_t;

    class latency_scoreboard;
        logic [31:0] budget;
        logic [63:0] counts  [lshm_pkg::LSHM_NUM_STAGES];
        logic [63:0] totals  [lshm_pkg::LSHM_NUM_STAGES];
        logic [63:0] maxima  [lshm_pkg::LSHM_NUM_STAGES];
        logic [63:0] recents [lshm_pkg::LSHM_NUM_STAGES];
        logic [63:0] overs   [lshm_pkg::LSHM_NUM_STAGES];
        logic [63:0] hist    [lshm_pkg::LSHM_NUM_STAGES][lshm_pkg::NUM_BUCKETS];
        logic [63:0] drops, replaced, stalls;
        lshm_pkg::result_t pending_stats[$];
        int          mismatches, checked, samples, refused, clears;

        function new();
            budget = '0;
            wipe();
        endfunction

        function void wipe();
            foreach (counts[i])
            begin
                counts[i]  = '0;
                totals[i]  = '0;
                maxima[i]  = '0;
                recents[i] = '0;
                overs[i]   = '0;
                for (int b = 0; b < lshm_pkg::NUM_BUCKETS; b++)
                    hist[i][b] = '0;
            end
            drops    = '0;
            replaced = '0;
            stalls   = '0;
        endfunction

        function int outstanding();
            return pending_stats.size();
        endfunction

        // Update the model for one accepted transaction and queue its expected report.
        function void note_request(stat_req_t rq);
            int          s;
            int          b;
            bit          found;
            logic [63:0] x, n, target, sum;
            lshm_pkg::result_t r;
            s = int'(rq.stage);
            r.accepted = 1'b1;
            case (rq.func)
                lshm_pkg::FN_RECORD:
                begin
                    if (rq.end_ns < rq.begin_ns)
                    begin
                        r.accepted = 1'b0;
                        refused++;
                    end
                    else
                    begin
                        x = rq.end_ns - rq.begin_ns;
                        samples++;
                        recents[s] = (counts[s] == 0) ? x
                                   : ((recents[s] * 64'd7 + x + 64'd4) >> 3);
                        counts[s] = counts[s] + 64'd1;
                        totals[s] = totals[s] + x;
                        if (x > maxima[s])
                            maxima[s] = x;
                        if (budget != 0 && x > {32'd0, budget})
                            overs[s] = overs[s] + 64'd1;
                        b = 0;
                        while (b < lshm_pkg::NUM_BUCKETS - 1 && x > BUCKET_TOP[b])
                            b++;
                        hist[s][b] = hist[s][b] + 64'd1;
                    end
                end
                lshm_pkg::FN_DROPS:    drops    = drops    + {32'd0, rq.event_count};
                lshm_pkg::FN_REPLACED: replaced = replaced + {32'd0, rq.event_count};
                lshm_pkg::FN_STALLS:   stalls   = stalls   + {32'd0, rq.event_count};
                lshm_pkg::FN_CLEAR:
                begin
                    wipe();
                    clears++;
                end
                default: ;
            endcase

            r.sample_count      = counts[s];
            r.total_time        = totals[s];
            r.max_time          = maxima[s];
            r.recent_time       = recents[s];
            r.over_budget_count = overs[s];
            r.drops_total       = drops;
            r.replaced_total    = replaced;
            r.stalls_total      = stalls;

            // p95: first bucket whose running sum reaches ceil(n*95/100)
            n = counts[s];
            r.p95_time = '0;
            if (n != 0)
            begin
                target = (n / 64'd100) * 64'd95 + ((n % 64'd100) * 64'd95 + 64'd99) / 64'd100;
                sum = '0;
                found = 1'b0;
                r.p95_time = BUCKET_TOP[lshm_pkg::NUM_BUCKETS-1];
                for (b = 0; b < lshm_pkg::NUM_BUCKETS; b++)
                begin
                    sum = sum + hist[s][b];
                    if (!found && sum >= target)
                    begin
                        r.p95_time = BUCKET_TOP[b];
                        found = 1'b1;
                    end
                end
            end
            pending_stats.push_back(r);
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(lshm_pkg::result_t got);
            lshm_pkg::result_t want;
            if (pending_stats.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                mismatches++;
                return;
            end
            want = pending_stats.pop_front();
            checked++;
            cmp("accepted", {63'd0, want.accepted}, {63'd0, got.accepted});
            cmp("sample_count", want.sample_count, got.sample_count);
            cmp("total_time", want.total_time, got.total_time);
            cmp("max_time", want.max_time, got.max_time);
            cmp("recent_time", want.recent_time, got.recent_time);
            cmp("over_budget_count", want.over_budget_count, got.over_budget_count);
            cmp("p95_time", want.p95_time, got.p95_time);
            cmp("drops_total", want.drops_total, got.drops_total);
            cmp("replaced_total", want.replaced_total, got.replaced_total);
            cmp("stalls_total", want.stalls_total, got.stalls_total);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    bit          jitter_on;
    int          quiet_cycles;
    int          budgets_used;

    latency_scoreboard sb;

    lshm_req_if req_ch ();
    lshm_rsp_if rsp_ch ();

    latency_stats_histogram_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(negedge clk)
        rsp_ch.ready <= !(jitter_on && $urandom_range(0, 99) < 27);

    always @(posedge clk)
    begin : collect_rsp
        lshm_pkg::result_t seen;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
        begin
            seen.accepted          = rsp_ch.accepted;
            seen.sample_count      = rsp_ch.sample_count;
            seen.total_time        = rsp_ch.total_time;
            seen.max_time          = rsp_ch.max_time;
            seen.recent_time       = rsp_ch.recent_time;
            seen.over_budget_count = rsp_ch.over_budget_count;
            seen.p95_time          = rsp_ch.p95_time;
            seen.drops_total       = rsp_ch.drops_total;
            seen.replaced_total    = rsp_ch.replaced_total;
            seen.stalls_total      = rsp_ch.stalls_total;
            sb.check_report(seen);
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no transaction for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic stat_req_t stat_req(logic [2:0] func, logic [5:0] stage,
                                           logic [63:0] t0, logic [63:0] t1,
                                           logic [31:0] amount);
        stat_req_t rq;
        rq.func        = func;
        rq.stage       = stage;
        rq.begin_ns    = t0;
        rq.end_ns      = t1;
        rq.event_count = amount;
        return rq;
    endfunction

    // Elapsed times clustered on bucket edges and on the current budget, plus small and fully random ones.
    function automatic logic [63:0] pick_elapsed();
        int          r;
        int          b;
        logic [63:0] lo, hi;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 64'($urandom_range(0, 1000));
        if (r < 70)
        begin
            b  = $urandom_range(0, lshm_pkg::NUM_BUCKETS - 1);
            lo = (b == 0) ? 64'd0 : BUCKET_TOP[b-1] + 64'd1;
            hi = (b == lshm_pkg::NUM_BUCKETS - 1) ? lo + 64'hFFFF_FFFF : BUCKET_TOP[b];
            case ($urandom_range(0, 3))
                0:       return hi;
                1:       return lo;
                default: return lo + rand64() % (hi - lo + 64'd1);
            endcase
        end
        if (r < 85)
            return {32'd0, sb.budget} + 64'd1 - 64'($urandom_range(0, 2));
        return rand64();
    endfunction

    function automatic stat_req_t random_req();
        stat_req_t   rq;
        int          r;
        int          hot;
        logic [63:0] x, a, c;
        r = $urandom_range(0, 199);
        if (r < 110)      rq.func = lshm_pkg::FN_RECORD;
        else if (r < 140) rq.func = lshm_pkg::FN_READ;
        else if (r < 156) rq.func = lshm_pkg::FN_DROPS;
        else if (r < 172) rq.func = lshm_pkg::FN_REPLACED;
        else if (r < 188) rq.func = lshm_pkg::FN_STALLS;
        else if (r < 194) rq.func = FN_SPARE6;
        else if (r < 199) rq.func = FN_SPARE7;
        else              rq.func = lshm_pkg::FN_CLEAR;

        // a few hot stages so per-stage counts and the histogram fill up
        hot = $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 60)
            rq.stage = (hot == 3) ? 6'd63 : 6'(hot);
        else
            rq.stage = 6'($urandom_range(0, 63));

        r = $urandom_range(0, 9);
        rq.event_count = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'd0 : $urandom;

        rq.begin_ns = rand64();
        rq.end_ns   = rand64();
        if (rq.func == lshm_pkg::FN_RECORD)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                a = rand64();
                c = rand64();
                if (a == c)
                    c = a ^ 64'd1;
                rq.begin_ns = (a > c) ? a : c;
                rq.end_ns   = (a > c) ? c : a;
            end
            else
            begin
                x = pick_elapsed();
                if (rq.begin_ns > ~x)
                    rq.begin_ns = rq.begin_ns & ~x;
                rq.end_ns = rq.begin_ns + x;
            end
        end
        return rq;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(stat_req_t rq);
        if (jitter_on && $urandom_range(0, 99) < 27)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= rq.func;
        req_ch.stage       <= rq.stage;
        req_ch.begin_ns    <= rq.begin_ns;
        req_ch.end_ns      <= rq.end_ns;
        req_ch.event_count <= rq.event_count;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(rq);
        @(negedge clk);
    endtask

    // Hold off the sender until every report is back and the block is idle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_budget(logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.budget = value;
    endtask

    initial
    begin
        logic [31:0] phase_budget [NUM_PHASES];
        stat_req_t   directed [$];
        sb = new();
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        jitter_on          = 1'b1;
        quiet_cycles       = 0;
        budgets_used       = 0;
        req_ch.valid       = 1'b0;
        req_ch.func        = lshm_pkg::FN_READ;
        req_ch.stage       = '0;
        req_ch.begin_ns    = '0;
        req_ch.end_ns      = '0;
        req_ch.event_count = '0;
        rsp_ch.ready       = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_budget(32'd1_000_000);
        budgets_used++;

        // bucket edges, wrap of the running sums, refused records, every func code
        directed.push_back(stat_req(lshm_pkg::FN_READ,     6'd0,  64'd0, 64'd0, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd0,  64'd0, 64'd0, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd0,  64'd5, 64'd100005, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd0,  64'd0, 64'd100001, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd0,  64'd1, 64'd500000001, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd0,  64'd0, 64'd500000001, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd63, MAX64, MAX64, 32'hFFFF_FFFF));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd63, 64'd0, MAX64, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd63, 64'd0, MAX64, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd63, MAX64, 64'd0, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd5,  64'd1, 64'd0, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd1,  64'd0, 64'd1000000, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd1,  64'd0, 64'd1000001, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_DROPS,    6'd1,  64'd0, 64'd0, 32'hFFFF_FFFF));
        directed.push_back(stat_req(lshm_pkg::FN_REPLACED, 6'd1,  64'd0, 64'd0, 32'hFFFF_FFFF));
        directed.push_back(stat_req(lshm_pkg::FN_STALLS,   6'd1,  64'd0, 64'd0, 32'd1));
        directed.push_back(stat_req(lshm_pkg::FN_DROPS,    6'd1,  64'd0, 64'd0, 32'd0));
        directed.push_back(stat_req(FN_SPARE6,             6'd0,  MAX64, 64'd0, 32'hFFFF_FFFF));
        directed.push_back(stat_req(FN_SPARE7,             6'd63, MAX64, 64'd0, 32'hFFFF_FFFF));
        directed.push_back(stat_req(lshm_pkg::FN_READ,     6'd63, 64'd0, 64'd0, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_CLEAR,    6'd0,  64'd0, 64'd0, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_READ,     6'd63, 64'd0, 64'd0, 32'd0));
        directed.push_back(stat_req(lshm_pkg::FN_RECORD,   6'd2,  rand64() >> 1, 64'd0, 32'd0));
        directed[directed.size()-1].end_ns = directed[directed.size()-1].begin_ns;
        foreach (directed[i])
            send_req(directed[i]);

        phase_budget = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd5_000_000, $urandom, 32'd100_000};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_budget(phase_budget[p]);
            budgets_used++;
            // one phase runs with both sides at full rate
            jitter_on = (p != 2);
            repeat (PHASE_ITEMS)
                send_req(random_req());
        end
        jitter_on = 1'b1;
        drain();

        if (sb.outstanding() != 0)
        begin
            $error("%0d expected results never arrived", sb.outstanding());
            sb.mismatches++;
        end
        $display("Covered %0d samples, %0d refused records and %0d clears under %0d budgets",
                 sb.samples, sb.refused, sb.clears, budgets_used);
        $display("%0d result transactions checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
